[rtl/cmlx_pkg.sv]
// Shared types, token codes and character-class functions for the C-minus scanner.
package cmlx_pkg;

  // Token length saturates here; the result field is clamped to eight bits.
  localparam int MaxTokenLength = 255;
  localparam int LenW           = $clog2(MaxTokenLength + 1);

  typedef logic [7:0]      char_t;
  typedef logic [4:0]      kind_t;
  typedef logic [1:0]      err_t;
  typedef logic [7:0]      tlen_t;
  typedef logic [LenW-1:0] cnt_t;
  typedef logic [47:0]     kwbuf_t;

  // One result as it sits in the output queue.
  typedef struct packed {
    kind_t kind;
    err_t  err;
    tlen_t len;
    logic  last;
  } result_t;

  // Token kinds.
  localparam kind_t K_ELSE   = 5'd0;
  localparam kind_t K_IF     = 5'd1;
  localparam kind_t K_INT    = 5'd2;
  localparam kind_t K_RETURN = 5'd3;
  localparam kind_t K_VOID   = 5'd4;
  localparam kind_t K_WHILE  = 5'd5;
  localparam kind_t K_ID     = 5'd6;
  localparam kind_t K_NUM    = 5'd7;
  localparam kind_t K_PLUS   = 5'd8;
  localparam kind_t K_MINUS  = 5'd9;
  localparam kind_t K_TIMES  = 5'd10;
  localparam kind_t K_DIV    = 5'd11;
  localparam kind_t K_LT     = 5'd12;
  localparam kind_t K_LTE    = 5'd13;
  localparam kind_t K_GT     = 5'd14;
  localparam kind_t K_GTE    = 5'd15;
  localparam kind_t K_EQ     = 5'd16;
  localparam kind_t K_NEQ    = 5'd17;
  localparam kind_t K_ASSIGN = 5'd18;
  localparam kind_t K_SEMI   = 5'd19;
  localparam kind_t K_COMMA  = 5'd20;
  localparam kind_t K_LPAREN = 5'd21;
  localparam kind_t K_RPAREN = 5'd22;
  localparam kind_t K_LBRACK = 5'd23;
  localparam kind_t K_RBRACK = 5'd24;
  localparam kind_t K_LBRACE = 5'd25;
  localparam kind_t K_RBRACE = 5'd26;
  localparam kind_t K_ERROR  = 5'd27;

  // Error codes.
  localparam err_t ERR_NONE    = 2'd0;
  localparam err_t ERR_INVALID = 2'd1;
  localparam err_t ERR_EOI     = 2'd2;

  // Keyword text, first character in the low byte.
  localparam kwbuf_t KW_ELSE   = 48'h0000_6573_6C65;
  localparam kwbuf_t KW_IF     = 48'h0000_0000_6669;
  localparam kwbuf_t KW_INT    = 48'h0000_0074_6E69;
  localparam kwbuf_t KW_RETURN = 48'h6E72_7574_6572;
  localparam kwbuf_t KW_VOID   = 48'h0000_6469_6F76;
  localparam kwbuf_t KW_WHILE  = 48'h0065_6C69_6877;

  function automatic logic is_letter(char_t c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(char_t c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_valid(char_t c);
    return ((c >= 8'h21) && (c <= 8'h7E)) || is_space(c);
  endfunction

  // Kind of a one-character delimiter or operator; K_ELSE means none.
  function automatic kind_t single_kind(char_t c);
    kind_t k;
    case (c)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_TIMES;
      8'h3B:   k = K_SEMI;
      8'h2C:   k = K_COMMA;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      default: k = K_ELSE;
    endcase
    return k;
  endfunction

  // Clamp a token count to the width of the result field.
  function automatic tlen_t clamp_len(cnt_t v);
    return (32'(v) > 255) ? 8'hFF : tlen_t'(v);
  endfunction

endpackage

[rtl/cmlx_if.sv]
// Channel interfaces for the scanner: character input and token result output.
interface cmlx_in_if;
  import cmlx_pkg::*;

  logic  valid;
  logic  ready;
  char_t character;
  logic  end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface cmlx_out_if;
  import cmlx_pkg::*;

  logic  valid;
  logic  ready;
  kind_t token_kind;
  err_t  error_code;
  tlen_t token_length;
  logic  last_of_run;

  modport source (output valid, output token_kind, output error_code, output token_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input error_code, input token_length,
                  input last_of_run, output ready);
endinterface

[rtl/c_minus_lexer_dfa.sv]
// C-minus lexical scanner: token automaton with a four-entry result queue.
//
// The block takes one ASCII character per transaction and can accept a new one in every
// clock cycle whenever at least two of the queue entries are free, which the queue depth
// sets. The automaton step, including the re-scan of a lookahead character from the start
// state, is done in the cycle of acceptance, and its zero, one or two results are written
// straight into a four-entry result queue. Results leave at one per cycle while the output
// is ready, so a character that ends one token and starts a one-character token gives two
// results that leave one after the other. End of input gives an error result with code 2
// and returns the automaton to the start state; a byte outside the character set, a byte
// that cannot start a token, or a '!' not followed by '=' gives an error result with code 1
// and also restarts the automaton. Results are registered in the queue before output.
module c_minus_lexer_dfa (
  input  logic              clk,
  input  logic              rst_n,
  cmlx_in_if.sink           in_ch,
  cmlx_out_if.source        out_ch
);
  import cmlx_pkg::*;

  // Automaton state codes.
  localparam logic [3:0] S_START       = 4'd0;
  localparam logic [3:0] S_ID          = 4'd1;
  localparam logic [3:0] S_NUM         = 4'd2;
  localparam logic [3:0] S_DIV         = 4'd3;
  localparam logic [3:0] S_LT          = 4'd4;
  localparam logic [3:0] S_GT          = 4'd5;
  localparam logic [3:0] S_EQ          = 4'd6;
  localparam logic [3:0] S_NEQ         = 4'd7;
  localparam logic [3:0] S_COMMENT     = 4'd8;
  localparam logic [3:0] S_COMMENT_END = 4'd9;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  logic [3:0]   st_r, st_nxt;
  kwbuf_t       kw_r, kw_nxt;
  cnt_t         len_r, len_nxt;

  result_t      q_mem [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCw-1:0] cnt_r, cnt_nxt;

  char_t        c;
  logic         in_acc, out_pop;
  logic         r0_vld, r1_vld;
  result_t      r0, r1;

  // Start-state step for the current character, used directly and after lookahead.
  logic         ss_vld, ss_tok;
  kind_t        ss_kind, ss_single;
  err_t         ss_err;
  logic [3:0]   ss_state;

  // Token bookkeeping helpers.
  cnt_t         len_inc;
  tlen_t        len_fail;
  kwbuf_t       kw_add;
  kind_t        id_kind;

  assign c       = in_ch.character;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_pop = out_ch.valid && out_ch.ready;

  // Start-state classification of the character.
  always_comb begin
    ss_single = single_kind(c);
    ss_vld    = 1'b0;
    ss_tok    = 1'b0;
    ss_kind   = K_ERROR;
    ss_err    = ERR_NONE;
    ss_state  = S_START;
    if (is_space(c)) begin
      ss_vld = 1'b0;
    end else if (ss_single != K_ELSE) begin
      ss_vld  = 1'b1;
      ss_kind = ss_single;
    end else if (is_letter(c)) begin
      ss_tok   = 1'b1;
      ss_state = S_ID;
    end else if (is_digit(c)) begin
      ss_tok   = 1'b1;
      ss_state = S_NUM;
    end else if (c == 8'h2F) begin
      ss_tok   = 1'b1;
      ss_state = S_DIV;
    end else if (c == 8'h3C) begin
      ss_tok   = 1'b1;
      ss_state = S_LT;
    end else if (c == 8'h3E) begin
      ss_tok   = 1'b1;
      ss_state = S_GT;
    end else if (c == 8'h3D) begin
      ss_tok   = 1'b1;
      ss_state = S_EQ;
    end else if (c == 8'h21) begin
      ss_tok   = 1'b1;
      ss_state = S_NEQ;
    end else begin
      ss_vld = 1'b1;
      ss_err = ERR_INVALID;
    end
  end

  // Saturating count, error length and keyword buffer with the character appended.
  always_comb begin
    len_inc  = (32'(len_r) >= MaxTokenLength) ? len_r : len_r + cnt_t'(1);
    len_fail = clamp_len(len_inc);
    kw_add   = kw_r;
    for (int i = 0; i < 6; i++) begin
      if (32'(len_r) == i) begin
        kw_add[8*i +: 8] = c;
      end
    end
  end

  // Keyword match on the buffered identifier text.
  always_comb begin
    id_kind = K_ID;
    if      ((32'(len_r) == 4) && (kw_r == KW_ELSE))   id_kind = K_ELSE;
    else if ((32'(len_r) == 2) && (kw_r == KW_IF))     id_kind = K_IF;
    else if ((32'(len_r) == 3) && (kw_r == KW_INT))    id_kind = K_INT;
    else if ((32'(len_r) == 6) && (kw_r == KW_RETURN)) id_kind = K_RETURN;
    else if ((32'(len_r) == 4) && (kw_r == KW_VOID))   id_kind = K_VOID;
    else if ((32'(len_r) == 5) && (kw_r == KW_WHILE))  id_kind = K_WHILE;
  end

  // Automaton step: next state and up to two results for one character.
  always_comb begin
    logic  la;
    kind_t la_kind;
    la      = 1'b0;
    la_kind = K_ID;
    st_nxt  = st_r;
    kw_nxt  = kw_r;
    len_nxt = len_r;
    r0_vld  = 1'b0;
    r1_vld  = 1'b0;
    r0      = '0;
    r1      = '0;

    if (in_ch.end_of_input) begin
      r0_vld  = 1'b1;
      r0.kind = K_ERROR;
      r0.err  = ERR_EOI;
      st_nxt  = S_START;
      kw_nxt  = '0;
      len_nxt = '0;
    end else if (!is_valid(c)) begin
      r0_vld  = 1'b1;
      r0.kind = K_ERROR;
      r0.err  = ERR_INVALID;
      r0.len  = len_fail;
      st_nxt  = S_START;
      kw_nxt  = '0;
      len_nxt = '0;
    end else begin
      unique case (st_r)
        S_ID: begin
          if (is_letter(c)) begin
            kw_nxt  = kw_add;
            len_nxt = len_inc;
          end else begin
            la      = 1'b1;
            la_kind = id_kind;
          end
        end
        S_NUM: begin
          if (is_digit(c)) begin
            kw_nxt  = kw_add;
            len_nxt = len_inc;
          end else begin
            la      = 1'b1;
            la_kind = K_NUM;
          end
        end
        S_DIV: begin
          if (c == 8'h2A) begin
            st_nxt  = S_COMMENT;
            kw_nxt  = '0;
            len_nxt = '0;
          end else begin
            la      = 1'b1;
            la_kind = K_DIV;
          end
        end
        S_LT: begin
          if (c == 8'h3D) begin
            r0_vld  = 1'b1;
            r0.kind = K_LTE;
            r0.len  = clamp_len(len_inc);
            st_nxt  = S_START;
            kw_nxt  = '0;
            len_nxt = '0;
          end else begin
            la      = 1'b1;
            la_kind = K_LT;
          end
        end
        S_GT: begin
          if (c == 8'h3D) begin
            r0_vld  = 1'b1;
            r0.kind = K_GTE;
            r0.len  = clamp_len(len_inc);
            st_nxt  = S_START;
            kw_nxt  = '0;
            len_nxt = '0;
          end else begin
            la      = 1'b1;
            la_kind = K_GT;
          end
        end
        S_EQ: begin
          if (c == 8'h3D) begin
            r0_vld  = 1'b1;
            r0.kind = K_EQ;
            r0.len  = clamp_len(len_inc);
            st_nxt  = S_START;
            kw_nxt  = '0;
            len_nxt = '0;
          end else begin
            la      = 1'b1;
            la_kind = K_ASSIGN;
          end
        end
        S_NEQ: begin
          r0_vld  = 1'b1;
          st_nxt  = S_START;
          kw_nxt  = '0;
          len_nxt = '0;
          if (c == 8'h3D) begin
            r0.kind = K_NEQ;
            r0.len  = clamp_len(len_inc);
          end else begin
            r0.kind = K_ERROR;
            r0.err  = ERR_INVALID;
            r0.len  = len_fail;
          end
        end
        S_COMMENT: begin
          if (c == 8'h2A) begin
            st_nxt = S_COMMENT_END;
          end
        end
        S_COMMENT_END: begin
          if (c == 8'h2F) begin
            st_nxt  = S_START;
            kw_nxt  = '0;
            len_nxt = '0;
          end else if (c != 8'h2A) begin
            st_nxt = S_COMMENT;
          end
        end
        default: begin
          // Start state: the character is scanned from scratch.
          r0_vld  = ss_vld;
          r0.kind = ss_kind;
          r0.err  = ss_err;
          r0.len  = 8'd1;
          st_nxt  = ss_state;
          kw_nxt  = ss_tok ? {40'b0, c} : '0;
          len_nxt = ss_tok ? cnt_t'(1) : '0;
        end
      endcase

      // Lookahead: emit the finished token, then rescan the character from start.
      if (la) begin
        r0_vld  = 1'b1;
        r0.kind = la_kind;
        r0.err  = ERR_NONE;
        r0.len  = clamp_len(len_r);
        r1_vld  = ss_vld;
        r1.kind = ss_kind;
        r1.err  = ss_err;
        r1.len  = 8'd1;
        st_nxt  = ss_state;
        kw_nxt  = ss_tok ? {40'b0, c} : '0;
        len_nxt = ss_tok ? cnt_t'(1) : '0;
      end
    end

    r0.last = !r1_vld;
    r1.last = 1'b1;
  end

  // Automaton registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_START;
      kw_r  <= '0;
      len_r <= '0;
    end else if (in_acc) begin
      st_r  <= st_nxt;
      kw_r  <= kw_nxt;
      len_r <= len_nxt;
    end
  end

  // Result queue occupancy.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + QCw'(r0_vld) + QCw'(r1_vld);
    end
    if (out_pop) begin
      cnt_nxt = cnt_nxt - QCw'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + QAw'(r0_vld) + QAw'(r1_vld);
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + QAw'(1);
      end
    end
  end

  // Result queue storage; the second result goes one slot after the first.
  always_ff @(posedge clk) begin
    if (in_acc && r0_vld) begin
      q_mem[wr_ptr_r] <= r0;
    end
    if (in_acc && r1_vld) begin
      q_mem[wr_ptr_r + QAw'(1)] <= r1;
    end
  end

  // Handshake and output payload.
  assign in_ch.ready         = (32'(cnt_r) <= QDepth - 2);
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.token_kind   = q_mem[rd_ptr_r].kind;
  assign out_ch.error_code   = q_mem[rd_ptr_r].err;
  assign out_ch.token_length = q_mem[rd_ptr_r].len;
  assign out_ch.last_of_run  = q_mem[rd_ptr_r].last;

  // The queue never holds more results than it has entries.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= QDepth)
    else $error("result queue overfilled");

  // End of input always leaves the automaton in the start state with no token.
  a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.end_of_input) |=> (st_r == S_START) && (len_r == '0))
    else $error("automaton not restarted after end of input");

  // A transaction with two results raises the occupancy by two, less any departure.
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && r1_vld) |=> cnt_r == $past(cnt_r) + QCw'(2) - QCw'($past(out_pop)))
    else $error("second result not queued");

  // A second result is only ever produced alongside a first one.
  a_r1_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && r1_vld) |-> (r0_vld && !r0.last))
    else $error("second result without a first");

endmodule

[tb/tb.sv]
// Self-checking testbench for the C-minus scanner: character stimulus, token prediction and checks.
`timescale 1ns / 100ps

module tb;
  import cmlx_pkg::*;

  // Scanner states as the prediction tracks them.
  typedef enum logic [3:0] {
    ST_START, ST_ID, ST_NUM, ST_DIV, ST_LT, ST_GT, ST_EQ, ST_NEQ, ST_COMMENT, ST_COMMENT_END
  } scan_state_t;

  // Tracks the token automaton, keeps the tokens still due and checks what arrives.
  class token_scoreboard_t;
    scan_state_t state;
    kwbuf_t      head_chars;
    int unsigned tok_count;
    result_t     step_out[$];
    result_t     due_tokens[$];
    int unsigned n_mismatch;
    int unsigned n_results;
    int unsigned n_error_results;

    function new();
      n_mismatch      = 0;
      n_results       = 0;
      n_error_results = 0;
      restart();
    endfunction

    function void clear_token();
      head_chars = '0;
      tok_count  = 0;
    endfunction

    function void restart();
      state = ST_START;
      clear_token();
    endfunction

    function logic letter_char(char_t c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic digit_char(char_t c);
      return c >= "0" && c <= "9";
    endfunction

    // Space, tab, line feed, vertical tab, form feed and carriage return.
    function logic blank_char(char_t c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function logic legal_char(char_t c);
      return (c >= "!" && c <= "~") || blank_char(c);
    endfunction

    // Kind of a one-character token; K_ERROR stands for none.
    function kind_t delimiter_kind(char_t c);
      case (c)
        "+":     return K_PLUS;
        "-":     return K_MINUS;
        "*":     return K_TIMES;
        ";":     return K_SEMI;
        ",":     return K_COMMA;
        "(":     return K_LPAREN;
        ")":     return K_RPAREN;
        "[":     return K_LBRACK;
        "]":     return K_RBRACK;
        "{":     return K_LBRACE;
        "}":     return K_RBRACE;
        default: return K_ERROR;
      endcase
    endfunction

    // The first six characters are kept, the count saturates.
    function void add_char(char_t c);
      if (tok_count < 6) head_chars[8*tok_count +: 8] = c;
      if (tok_count < MaxTokenLength) tok_count++;
    endfunction

    function void emit(kind_t k, err_t e, int unsigned n);
      result_t r;
      if (step_out.size() >= 2) return;
      r.kind = k;
      r.err  = e;
      r.len  = (n > 255) ? 8'hFF : tlen_t'(n);
      r.last = 1'b0;
      step_out = {step_out, r};
    endfunction

    function void finish_token(kind_t k);
      emit(k, ERR_NONE, tok_count);
      clear_token();
      state = ST_START;
    endfunction

    // A bad byte counts towards the length of the failed token.
    function void reject();
      int unsigned n;
      n = tok_count + 1;
      if (n > MaxTokenLength) n = MaxTokenLength;
      emit(K_ERROR, ERR_INVALID, n);
      restart();
    endfunction

    function logic is_word(string w);
      kwbuf_t packed_w;
      packed_w = '0;
      for (int i = 0; i < w.len(); i++) packed_w[8*i +: 8] = w[i];
      return tok_count == w.len() && head_chars == packed_w;
    endfunction

    // Keywords match exactly, including case and length.
    function kind_t word_kind();
      if (is_word("else"))   return K_ELSE;
      if (is_word("if"))     return K_IF;
      if (is_word("int"))    return K_INT;
      if (is_word("return")) return K_RETURN;
      if (is_word("void"))   return K_VOID;
      if (is_word("while"))  return K_WHILE;
      return K_ID;
    endfunction

    function void from_start(char_t c);
      kind_t sk;
      sk = delimiter_kind(c);
      clear_token();
      if (blank_char(c)) begin
        state = ST_START;
        return;
      end
      if (sk != K_ERROR) begin
        add_char(c);
        finish_token(sk);
        return;
      end
      if (letter_char(c))     state = ST_ID;
      else if (digit_char(c)) state = ST_NUM;
      else if (c == "/")      state = ST_DIV;
      else if (c == "<")      state = ST_LT;
      else if (c == ">")      state = ST_GT;
      else if (c == "=")      state = ST_EQ;
      else if (c == "!")      state = ST_NEQ;
      else begin
        reject();
        return;
      end
      add_char(c);
    endfunction

    // The ending character is scanned again from the start state.
    function void lookahead(kind_t k, char_t c);
      finish_token(k);
      from_start(c);
    endfunction

    // Notes an accepted character and queues the tokens it causes.
    function void note_char(char_t c, logic eoi);
      result_t r;
      step_out.delete();
      if (eoi) begin
        emit(K_ERROR, ERR_EOI, 0);
        restart();
      end else if (!legal_char(c)) begin
        reject();
      end else begin
        case (state)
          ST_ID: begin
            if (letter_char(c)) add_char(c);
            else lookahead(word_kind(), c);
          end
          ST_NUM: begin
            if (digit_char(c)) add_char(c);
            else lookahead(K_NUM, c);
          end
          ST_DIV: begin
            if (c == "*") begin
              clear_token();
              state = ST_COMMENT;
            end else lookahead(K_DIV, c);
          end
          ST_LT: begin
            if (c == "=") begin
              add_char(c);
              finish_token(K_LTE);
            end else lookahead(K_LT, c);
          end
          ST_GT: begin
            if (c == "=") begin
              add_char(c);
              finish_token(K_GTE);
            end else lookahead(K_GT, c);
          end
          ST_EQ: begin
            if (c == "=") begin
              add_char(c);
              finish_token(K_EQ);
            end else lookahead(K_ASSIGN, c);
          end
          ST_NEQ: begin
            if (c == "=") begin
              add_char(c);
              finish_token(K_NEQ);
            end else reject();
          end
          ST_COMMENT: begin
            if (c == "*") state = ST_COMMENT_END;
          end
          ST_COMMENT_END: begin
            if (c == "/") restart();
            else if (c != "*") state = ST_COMMENT;
          end
          default: from_start(c);
        endcase
      end
      foreach (step_out[i]) begin
        r = step_out[i];
        r.last = (i == step_out.size() - 1);
        due_tokens = {due_tokens, r};
      end
    endfunction

    task report(string what);
      $display("tb: MISMATCH at %0t ns: %s", $time, what);
      n_mismatch++;
    endtask

    // Compares one accepted token with the oldest one due.
    task check_token(kind_t k, err_t e, tlen_t n, logic last);
      result_t want;
      n_results++;
      if (k == K_ERROR) n_error_results++;
      if (due_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d code %0d length %0d", k, e, n));
        return;
      end
      want = due_tokens.pop_front();
      if (k != want.kind)
        report($sformatf("token_kind %0d, predicted %0d", k, want.kind));
      if (e != want.err)
        report($sformatf("error_code %0d, predicted %0d", e, want.err));
      if (n != want.len)
        report($sformatf("token_length %0d, predicted %0d", n, want.len));
      if (last != want.last)
        report($sformatf("last_of_run %0d, predicted %0d", last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  cmlx_in_if  char_if ();
  cmlx_out_if token_if ();

  c_minus_lexer_dfa DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_if),
    .out_ch (token_if)
  );

  token_scoreboard_t sb;
  char_t             burst[$];
  int unsigned       chars_sent;
  logic              idle_on;
  logic              stall_on;

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Sends one character; returns at the edge where the transaction takes place.
  task automatic send_item(char_t c, logic eoi);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid        <= 1'b1;
    char_if.character    <= c;
    char_if.end_of_input <= eoi;
    do @(posedge clk); while (!char_if.ready);
    sb.note_char(c, eoi);
    chars_sent++;
  endtask

  // Sends every byte collected in the burst queue.
  task automatic send_burst();
    while (burst.size() != 0) send_item(burst.pop_front(), 1'b0);
  endtask

  // Appends one byte to the burst queue.
  task automatic put_byte(char_t b);
    burst = {burst, b};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Holds the input back until every predicted token has come out.
  task automatic drain();
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (sb.due_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic char_t rand_letter();
    return $urandom_range(0, 1) ? char_t'($urandom_range("a", "z"))
                                : char_t'($urandom_range("A", "Z"));
  endfunction

  function automatic char_t rand_blank();
    case ($urandom_range(0, 5))
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Queues one well-formed token, now and then with a keyword bent out of shape.
  task automatic add_token();
    string words[6];
    string ops[19];
    int    n;
    words = '{"else", "if", "int", "return", "void", "while"};
    ops   = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=", "=", ";", ",",
              "(", ")", "[", "]", "{", "}"};
    case ($urandom_range(0, 8))
      0, 1: begin
        add_text(words[$urandom_range(0, 5)]);
        case ($urandom_range(0, 5))
          0: burst[burst.size() - 1] = rand_letter();
          1: put_byte(rand_letter());
          2: burst[0] = burst[0] ^ 8'h20;
          default: ;
        endcase
      end
      2, 3: begin
        n = $urandom_range(1, 8);
        repeat (n) put_byte(rand_letter());
      end
      4: begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(char_t'($urandom_range("0", "9")));
      end
      5, 6, 7: add_text(ops[$urandom_range(0, 18)]);
      default: begin
        // Comment with mixed text and a run of closing stars.
        add_text("/*");
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       put_byte("*");
            1:       put_byte("/");
            2:       put_byte(rand_blank());
            default: put_byte(char_t'($urandom_range(8'h21, 8'h7E)));
          endcase
        end
        n = $urandom_range(1, 3);
        repeat (n) put_byte("*");
        put_byte("/");
      end
    endcase
    if ($urandom_range(0, 1)) put_byte(rand_blank());
  endtask

  // Queues a token that is cut short or broken.
  task automatic add_broken();
    case ($urandom_range(0, 2))
      0: begin
        put_byte("!");
        put_byte(char_t'($urandom_range(0, 255)));
      end
      1: begin
        add_text("/*");
        put_byte(char_t'($urandom_range(0, 255)));
      end
      default: begin
        put_byte(rand_letter());
        put_byte(char_t'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Result side: random stalls, every transaction checked.
  initial begin
    int gap;
    token_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = stall_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
        @(negedge clk);
        token_if.ready <= 1'b0;
      end
      @(negedge clk);
      token_if.ready <= 1'b1;
      do @(posedge clk); while (!token_if.valid);
      sb.check_token(token_if.token_kind, token_if.error_code, token_if.token_length,
                     token_if.last_of_run);
    end
  end

  // Reset, directed characters, random token streams and the end of the run.
  initial begin
    int  r;
    int  next_flip;
    int  n;
    logic long_done;
    logic drain_done;
    sb                   = new();
    rst_n                = 1'b0;
    char_if.valid        = 1'b0;
    char_if.character    = '0;
    char_if.end_of_input = 1'b0;
    chars_sent           = 0;
    idle_on              = 1'b1;
    stall_on             = 1'b1;
    long_done            = 1'b0;
    drain_done           = 1'b0;
    next_flip            = 40;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Keyword, keyword with an extra letter, lookahead, comment with star runs, broken
    // not-equal, bytes outside the character set and end of input.
    add_text("if returns<=y/**x**/!;");
    send_burst();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(char_t'($urandom_range(0, 255)), 1'b1);

    while (chars_sent < 675) begin
      if (chars_sent >= next_flip) begin
        idle_on   = ($urandom_range(0, 3) != 0);
        stall_on  = ($urandom_range(0, 3) != 0);
        next_flip = chars_sent + 40;
      end
      if (!drain_done && chars_sent > 200) begin
        drain();
        drain_done = 1'b1;
      end
      if (!long_done && chars_sent > 350) begin
        // Saturating lengths: a long identifier ended by a delimiter and a long
        // number ended by a byte outside the character set.
        n = 256 + $urandom_range(0, 8);
        repeat (n) put_byte(rand_letter());
        put_byte(";");
        n = 255 + $urandom_range(0, 8);
        repeat (n) put_byte(char_t'($urandom_range("0", "9")));
        put_byte(8'h80);
        send_burst();
        long_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 80) add_token();
      else if (r < 88) put_byte(char_t'($urandom_range(0, 255)));
      else if (r < 93) begin
        send_burst();
        send_item(char_t'($urandom_range(0, 255)), 1'b1);
      end else add_broken();
      send_burst();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d characters sent, %0d tokens checked, %0d of them error tokens",
             chars_sent, sb.n_results, sb.n_error_results);
    $display("tb: %0d mismatches, %0d tokens still due", sb.n_mismatch, sb.due_tokens.size());
    if (sb.n_mismatch == 0 && sb.due_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
